// ===== rtl/pkms_pkg.sv =====
// shared widths, codes and types of the per-key magnitude statistics block
`default_nettype none

package pkms_pkg;

    localparam int MAG_W      = 16;
    localparam int SLOT_W     = 6;
    localparam int STATUS_W   = 3;
    localparam int MIN_OBS_W  = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_REPORT  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAG_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_OBS   = 1'd1;

    localparam logic [STATUS_W-1:0] STAT_ACCEPTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_REJECTED  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_REPORT_OK = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd4;

    localparam logic [MAG_W-1:0]     MAG_LIMIT_RST = 16'd20000;
    localparam logic [MIN_OBS_W-1:0] MIN_OBS_RST   = 24'd16;

    typedef struct packed {
        logic [MAG_W-1:0] mean;
        logic [MAG_W-1:0] deviation;
        logic             variable_flag;
    } t_rep_res;

endpackage

`default_nettype wire

// ===== rtl/per_key_magnitude_statistics.sv =====
// top level of the per-key magnitude statistics table
//
//  channel | dir | handshake                  | beat contents
//  --------+-----+----------------------------+------------------------------------------
//  s_*     | in  | s_tvalid / s_tready        | tuser: operation; tdata: slot, magnitude
//  m_*     | out | m_tvalid / m_tready        | tuser: status; tdata: statistics of slot
//  cfg     | in  | i_cfg_valid / o_cfg_ready  | register index and write data
//
//  an observe beat holds the block from accept to its result: row read at accept, squared
//  magnitude formed in the read step, row updated, written back and result registered
//  in the update step; a report of two or more samples runs the shared bit-serial
//  multiplier, restoring divider and square root, a single sample only the mean divide,
//  an empty slot answers in the update step; s_tready rises as the result is registered
//  after reset a clearing pass writes every row with s_tready low
//  a stalled result holds the item in its update or report step; no write happens until
//  it leaves
`default_nettype none

module per_key_magnitude_statistics
    import pkms_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int COUNT_WIDTH = 24
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // input beats
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [23:0]                s_tdata,   // slot_index[5:0], magnitude[21:6]
    input  wire logic                       s_tuser,   // operation
    // result beats
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // mean, deviation, brightest_seen, dimmest_seen, observation_count, variable_flag
    output logic [((4*16+COUNT_WIDTH+1+7)/8)*8-1:0] m_tdata,
    output logic [STATUS_W-1:0]             m_tuser,   // status
    // configuration writes
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int TW  = $clog2(TABLE_DEPTH);
    localparam int CW  = COUNT_WIDTH;
    localparam int SW  = CW + MAG_W;
    localparam int QW  = CW + 2 * MAG_W;
    localparam int RW  = CW + SW + QW + 2 * MAG_W;
    localparam int ODW = ((4 * MAG_W + CW + 1 + 7) / 8) * 8;

    localparam logic [2:0] T_CLEAR  = 3'd0;
    localparam logic [2:0] T_IDLE   = 3'd1;
    localparam logic [2:0] T_READ   = 3'd2;
    localparam logic [2:0] T_UPDATE = 3'd3;
    localparam logic [2:0] T_REPORT = 3'd4;

    logic [2:0]           r_state;
    logic [TW-1:0]        r_clr_addr;
    logic                 r_op;
    logic [TW-1:0]        r_slot;
    logic [MAG_W-1:0]     r_mag;
    logic [2*MAG_W-1:0]   r_magsq;
    logic [MAG_W-1:0]     r_mag_limit;
    logic [MIN_OBS_W-1:0] r_min_obs;
    logic                 r_m_tvalid;
    logic [ODW-1:0]       r_m_tdata;
    logic [STATUS_W-1:0]  r_m_tuser;

    logic           accept;
    logic           out_free;
    logic           out_load;
    logic [TW-1:0]  slot_in;
    logic           ram_we;
    logic [TW-1:0]  ram_waddr;
    logic [RW-1:0]  ram_wdata;
    logic [RW-1:0]  rdata;

    logic [CW-1:0]    rd_n;
    logic [SW-1:0]    rd_s;
    logic [QW-1:0]    rd_q;
    logic [MAG_W-1:0] rd_br;
    logic [MAG_W-1:0] rd_dm;

    logic [CW-1:0]    up_n;
    logic [SW-1:0]    up_s;
    logic [QW-1:0]    up_q;
    logic [MAG_W-1:0] up_br;
    logic [MAG_W-1:0] up_dm;
    logic             first_obs;
    logic             obs_rejected;
    logic             obs_full;

    logic     rep_start;
    logic     rep_busy;
    t_rep_res rep_res;

    assign s_tready    = (r_state == T_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign out_free    = !r_m_tvalid || m_tready;
    assign o_cfg_ready = 1'b1;

    // a result beat is loaded into the output register this cycle
    assign out_load = ((r_state == T_UPDATE) && out_free
                       && (r_op == OP_OBSERVE || first_obs))
                      || ((r_state == T_REPORT) && !rep_busy && out_free);

    // slot wraps modulo the table depth; compare-subtract steps on the six slot bits, one per bit
    always_comb begin
        int rem;
        rem = int'(s_tdata[SLOT_W-1:0]);
        for (int k = SLOT_W - 1; k >= 0; k--) begin
            if (rem >= (TABLE_DEPTH << k)) begin
                rem = rem - (TABLE_DEPTH << k);
            end
        end
        slot_in = TW'(rem);
    end

    // row layout, count in the low bits
    assign rd_n  = rdata[CW-1:0];
    assign rd_s  = rdata[CW +: SW];
    assign rd_q  = rdata[CW+SW +: QW];
    assign rd_br = rdata[CW+SW+QW +: MAG_W];
    assign rd_dm = rdata[CW+SW+QW+MAG_W +: MAG_W];

    // observe update of the row just read
    assign first_obs    = (rd_n == '0);
    assign obs_rejected = (r_mag > r_mag_limit);
    assign obs_full     = (rd_n == {CW{1'b1}});
    assign up_n  = rd_n + CW'(1);
    assign up_s  = first_obs ? SW'(r_mag) : rd_s + SW'(r_mag);
    assign up_q  = first_obs ? QW'(r_magsq) : rd_q + QW'(r_magsq);
    assign up_br = (first_obs || r_mag < rd_br) ? r_mag : rd_br;
    assign up_dm = (first_obs || r_mag > rd_dm) ? r_mag : rd_dm;

    // write port: clearing pass or observe write-back
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_wdata = {up_dm, up_br, up_q, up_s, up_n};
        if (r_state == T_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (r_state == T_UPDATE && r_op == OP_OBSERVE && out_free
                     && !obs_rejected && !obs_full) begin
            ram_we = 1'b1;
        end
    end

    pkms_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (slot_in),
        .o_rdata (rdata)
    );

    // report math runs on the row held at the ram output
    assign rep_start = (r_state == T_UPDATE) && (r_op == OP_REPORT) && !first_obs;

    pkms_report #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_report (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (rep_start),
        .i_count   (rd_n),
        .i_sum     (rd_s),
        .i_sqsum   (rd_q),
        .i_bright  (rd_br),
        .i_dim     (rd_dm),
        .i_min_obs (r_min_obs),
        .o_busy    (rep_busy),
        .o_res     (rep_res)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_limit <= MAG_LIMIT_RST;
            r_min_obs   <= MIN_OBS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAG_LIMIT: r_mag_limit <= i_cfg_data[MAG_W-1:0];
                CFG_MIN_OBS:   r_min_obs   <= i_cfg_data[MIN_OBS_W-1:0];
            endcase
        end
    end

    // item capture and squared magnitude
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= s_tuser;
            r_slot <= slot_in;
            r_mag  <= s_tdata[SLOT_W +: MAG_W];
        end
        if (r_state == T_READ) begin
            r_magsq <= r_mag * r_mag;
        end
    end

    // control and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= T_CLEAR;
            r_clr_addr <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_m_tvalid <= 1'b1;
            end else if (m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                T_CLEAR: begin
                    r_clr_addr <= r_clr_addr + TW'(1);
                    if (r_clr_addr == TW'(TABLE_DEPTH - 1)) begin
                        r_state <= T_IDLE;
                    end
                end
                T_IDLE: begin
                    if (accept) begin
                        r_state <= T_READ;
                    end
                end
                T_READ: begin
                    r_state <= T_UPDATE;
                end
                T_UPDATE: begin
                    case (r_op)
                        OP_OBSERVE: begin
                            if (out_free) begin
                                r_m_tdata  <= '0;
                                if (obs_rejected) begin
                                    r_m_tuser <= STAT_REJECTED;
                                end else if (obs_full) begin
                                    r_m_tuser <= STAT_FULL;
                                end else begin
                                    r_m_tuser <= STAT_ACCEPTED;
                                end
                                r_state <= T_IDLE;
                            end
                        end
                        default: begin
                            if (!first_obs) begin
                                r_state <= T_REPORT;
                            end else if (out_free) begin
                                r_m_tdata  <= '0;
                                r_m_tuser  <= STAT_EMPTY;
                                r_state    <= T_IDLE;
                            end
                        end
                    endcase
                end
                T_REPORT: begin
                    if (!rep_busy && out_free) begin
                        r_m_tuser  <= STAT_REPORT_OK;
                        r_m_tdata  <= ODW'({rep_res.variable_flag, rd_n, rd_dm, rd_br,
                                            rep_res.deviation, rep_res.mean});
                        r_state    <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;
    assign m_tuser  = r_m_tuser;

endmodule

`default_nettype wire

// ===== rtl/pkms_ram.sv =====
// generic single-port-write, registered-read ram
`default_nettype none

module pkms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pkms_report.sv =====
// report sequencer: serial multiplier, restoring divider and square root
`default_nettype none

module pkms_report
    import pkms_pkg::*;
#(
    parameter int COUNT_WIDTH = 24
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [COUNT_WIDTH-1:0]         i_count,
    input  wire logic [COUNT_WIDTH+MAG_W-1:0]   i_sum,
    input  wire logic [COUNT_WIDTH+2*MAG_W-1:0] i_sqsum,
    input  wire logic [MAG_W-1:0]               i_bright,
    input  wire logic [MAG_W-1:0]               i_dim,
    input  wire logic [MIN_OBS_W-1:0]           i_min_obs,
    output logic                                o_busy,
    output t_rep_res                            o_res
);

    localparam int CW   = COUNT_WIDTH;
    localparam int SW   = CW + MAG_W;
    localparam int QW   = CW + 2 * MAG_W;
    localparam int NW   = 2 * CW + 2 * MAG_W;
    localparam int DW   = 2 * CW;
    localparam int VQW  = 2 * MAG_W;
    localparam int BW   = (SW > VQW) ? SW : VQW;
    localparam int STW  = $clog2(BW + 1);
    localparam int CMW  = SW + 4;
    localparam int MXW  = (CW > MIN_OBS_W) ? CW : MIN_OBS_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_NSQ   = 4'd1;
    localparam logic [3:0] S_SS    = 4'd2;
    localparam logic [3:0] S_NN1   = 4'd3;
    localparam logic [3:0] S_DVAR  = 4'd4;
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_R2    = 4'd6;
    localparam logic [3:0] S_LHS   = 4'd7;
    localparam logic [3:0] S_NSUM  = 4'd8;
    localparam logic [3:0] S_NR    = 4'd9;
    localparam logic [3:0] S_DMEAN = 4'd10;

    logic [3:0]           r_state;
    logic                 r_load;
    logic [STW-1:0]       r_cnt;
    logic [CW-1:0]        r_n;
    logic [SW-1:0]        r_s;
    logic [QW-1:0]        r_qsum;
    logic [MAG_W-1:0]     r_br;
    logic [MAG_W-1:0]     r_dm;
    logic [MIN_OBS_W-1:0] r_minobs;
    logic [NW-1:0]        r_ma;
    logic [BW-1:0]        r_mb;
    logic [NW-1:0]        r_p;
    logic [NW-1:0]        r_t;
    logic [NW-1:0]        r_num;
    logic [DW-1:0]        r_nn1;
    logic [VQW-1:0]       r_r2;
    logic [CW+MAG_W:0]    r_nsum;
    logic                 r_crange;
    logic                 r_ccenter;
    logic [DW-1:0]        r_dd;
    logic [DW-1:0]        r_dr;
    logic [VQW-1:0]       r_dq;
    logic [VQW-1:0]       r_sx;
    logic [MAG_W+1:0]     r_sr;
    logic [MAG_W-1:0]     r_root;
    logic [MAG_W-1:0]     r_mean;
    logic [MAG_W-1:0]     r_dev;
    logic                 r_flag;

    logic [MAG_W-1:0] range;
    logic [NW-1:0]    ld_a;
    logic [BW-1:0]    ld_b;
    logic [NW-1:0]    p_next;
    logic [DW:0]      dv_t;
    logic [DW:0]      dv_sub;
    logic             dv_ge;
    logic [DW-1:0]    dr_next;
    logic [VQW-1:0]   dq_next;
    logic [MAG_W+3:0] sq_t;
    logic [MAG_W+3:0] sq_trial;
    logic [MAG_W+3:0] sq_sub;
    logic             sq_ge;
    logic [MAG_W+1:0] sr_next;
    logic [MAG_W-1:0] root_next;
    logic             mul_last;
    logic [NW+3:0]    nine_num;
    logic [CMW-1:0]   a10;
    logic [CMW-1:0]   b5;
    logic [CMW-1:0]   diff;
    logic [CMW-1:0]   nr2;

    assign range = r_dm - r_br;

    // operand select for the shared multiplier
    always_comb begin
        ld_a = '0;
        ld_b = '0;
        unique case (r_state)
            S_NSQ: begin
                ld_a = NW'(r_qsum);
                ld_b = BW'(r_n);
            end
            S_SS: begin
                ld_a = NW'(r_s);
                ld_b = BW'(r_s);
            end
            S_NN1: begin
                ld_a = NW'(r_n);
                ld_b = BW'(r_n - CW'(1));
            end
            S_R2: begin
                ld_a = NW'(range);
                ld_b = BW'(range);
            end
            S_LHS: begin
                ld_a = NW'(r_nn1);
                ld_b = BW'(r_r2);
            end
            S_NSUM: begin
                ld_a = NW'(r_n);
                ld_b = BW'({1'b0, r_dm} + {1'b0, r_br});
            end
            S_NR: begin
                ld_a = NW'(r_n);
                ld_b = BW'(range);
            end
            default: begin
                ld_a = '0;
                ld_b = '0;
            end
        endcase
    end

    assign p_next   = r_p + (r_mb[0] ? r_ma : '0);
    assign mul_last = (r_cnt == STW'(BW - 1));

    // one restoring divide step
    assign dv_t    = {r_dr, r_dq[VQW-1]};
    assign dv_sub  = dv_t - {1'b0, r_dd};
    assign dv_ge   = (dv_t >= {1'b0, r_dd});
    assign dr_next = dv_ge ? dv_sub[DW-1:0] : dv_t[DW-1:0];
    assign dq_next = {r_dq[VQW-2:0], dv_ge};

    // one square root digit
    assign sq_t      = {r_sr, r_sx[VQW-1 -: 2]};
    assign sq_trial  = {2'b00, r_root, 2'b01};
    assign sq_sub    = sq_t - sq_trial;
    assign sq_ge     = (sq_t >= sq_trial);
    assign sr_next   = sq_ge ? sq_sub[MAG_W+1:0] : sq_t[MAG_W+1:0];
    assign root_next = {r_root[MAG_W-2:0], sq_ge};

    // spread and centering tests, all exact in integers
    assign nine_num = ((NW+4)'(r_num) << 3) + (NW+4)'(r_num);
    assign a10      = (CMW'(r_s) << 3) + (CMW'(r_s) << 1);
    assign b5       = (CMW'(r_nsum) << 2) + CMW'(r_nsum);
    assign diff     = (a10 > b5) ? (a10 - b5) : (b5 - a10);
    assign nr2      = CMW'(p_next[CW+MAG_W-1:0]) << 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_load  <= 1'b0;
        end else begin
            if (r_load) begin
                r_load <= 1'b0;
                r_cnt  <= '0;
                r_ma   <= ld_a;
                r_mb   <= ld_b;
                r_p    <= '0;
                if (r_state == S_DVAR) begin
                    r_dr <= r_num[NW-1:VQW];
                    r_dq <= r_num[VQW-1:0];
                    r_dd <= r_nn1;
                end else if (r_state == S_DMEAN) begin
                    r_dr <= DW'(r_s[SW-1:MAG_W]);
                    r_dq <= {r_s[MAG_W-1:0], {MAG_W{1'b0}}};
                    r_dd <= DW'(r_n);
                end else if (r_state == S_SQRT) begin
                    r_sx   <= r_dq;
                    r_sr   <= '0;
                    r_root <= '0;
                end
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (i_start) begin
                            r_n      <= i_count;
                            r_s      <= i_sum;
                            r_qsum   <= i_sqsum;
                            r_br     <= i_bright;
                            r_dm     <= i_dim;
                            r_minobs <= i_min_obs;
                            r_load   <= 1'b1;
                            if (i_count > CW'(1)) begin
                                r_state <= S_NSQ;
                            end else begin
                                r_dev   <= '0;
                                r_state <= S_DMEAN;
                            end
                        end
                    end
                    S_NSQ, S_SS, S_NN1, S_R2, S_LHS, S_NSUM, S_NR: begin
                        r_p   <= p_next;
                        r_ma  <= r_ma << 1;
                        r_mb  <= r_mb >> 1;
                        r_cnt <= r_cnt + STW'(1);
                        if (mul_last) begin
                            r_load <= 1'b1;
                            unique case (r_state)
                                S_NSQ: begin
                                    r_t     <= p_next;
                                    r_state <= S_SS;
                                end
                                S_SS: begin
                                    r_num   <= r_t - p_next;
                                    r_state <= S_NN1;
                                end
                                S_NN1: begin
                                    r_nn1   <= p_next[DW-1:0];
                                    r_state <= S_DVAR;
                                end
                                S_R2: begin
                                    r_r2    <= p_next[VQW-1:0];
                                    r_state <= S_LHS;
                                end
                                S_LHS: begin
                                    r_crange <= ((NW+4)'(p_next) < nine_num);
                                    r_state  <= S_NSUM;
                                end
                                S_NSUM: begin
                                    r_nsum  <= p_next[CW+MAG_W:0];
                                    r_state <= S_NR;
                                end
                                default: begin
                                    r_ccenter <= (diff < nr2);
                                    r_state   <= S_DMEAN;
                                end
                            endcase
                        end
                    end
                    S_DVAR, S_DMEAN: begin
                        r_dr  <= dr_next;
                        r_dq  <= dq_next;
                        r_cnt <= r_cnt + STW'(1);
                        if (r_state == S_DVAR && r_cnt == STW'(VQW - 1)) begin
                            r_load  <= 1'b1;
                            r_state <= S_SQRT;
                        end else if (r_state == S_DMEAN && r_cnt == STW'(MAG_W - 1)) begin
                            r_mean  <= dq_next[MAG_W-1:0];
                            r_flag  <= (r_n > CW'(1)) && (MXW'(r_n) >= MXW'(r_minobs))
                                       && r_crange && r_ccenter;
                            r_state <= S_IDLE;
                        end
                    end
                    S_SQRT: begin
                        r_sx   <= r_sx << 2;
                        r_sr   <= sr_next;
                        r_root <= root_next;
                        r_cnt  <= r_cnt + STW'(1);
                        if (r_cnt == STW'(MAG_W - 1)) begin
                            r_dev   <= root_next;
                            r_load  <= 1'b1;
                            r_state <= S_R2;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_busy              = (r_state != S_IDLE);
    assign o_res.mean          = r_mean;
    assign o_res.deviation     = r_dev;
    assign o_res.variable_flag = r_flag;

endmodule

`default_nettype wire
